[design/pcc_pkg.sv]
// Shared types and constants for the palette color cycler
package pcc_pkg;

  localparam int unsigned PAL_ENTRIES = 256;
  localparam int unsigned MAX_RANGES  = 9;
  localparam int unsigned IDX_W       = $clog2(PAL_ENTRIES);
  localparam int unsigned RNG_W       = $clog2(MAX_RANGES);
  localparam int unsigned CNT_W       = 4;
  localparam int unsigned COLOR_W     = 18;
  localparam int unsigned FIELD_W     = 9;
  localparam int unsigned QDEPTH      = 2;

  typedef enum logic [1:0] {
    ACT_WRITE = 2'd0,
    ACT_READ  = 2'd1,
    ACT_ADD   = 2'd2,
    ACT_TICK  = 2'd3
  } action_t;

  // Classified command handed from front to back
  typedef struct packed {
    action_t              act;
    logic [IDX_W-1:0]     idx;
    logic                 idx_ok;
    logic [COLOR_W-1:0]   color;
    logic                 clear;
    logic                 add_ok;
    logic [IDX_W-1:0]     first;
    logic [FIELD_W-1:0]   len;
    logic [FIELD_W-1:0]   shift;
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SNAP,
    ST_RNG,
    ST_RD,
    ST_WR,
    ST_OUT
  } bstate_t;

endpackage

[design/pcc_front.sv]
// Front end: classify incoming items and push them into the command queue
module pcc_front (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic [1:0]                             in_action,
  input  logic [pcc_pkg::IDX_W-1:0]              in_entry_index,
  input  logic [pcc_pkg::COLOR_W-1:0]            in_entry_color,
  input  logic signed [pcc_pkg::FIELD_W-1:0]     in_range_first,
  input  logic [pcc_pkg::FIELD_W-1:0]            in_range_length,
  input  logic signed [pcc_pkg::FIELD_W-1:0]     in_range_shift,
  output logic                                   q_valid,
  output pcc_pkg::cmd_t                          q_cmd,
  input  logic                                   q_pop
);
  import pcc_pkg::*;

  cmd_t                    mem_r [QDEPTH];
  logic [$clog2(QDEPTH):0] cnt_r, cnt_nxt;
  logic                    wp_r, rp_r;
  logic                    push;
  cmd_t                    c;
  logic signed [FIELD_W+1:0] eff_sh, end_sum;

  // Classify the add-range bounds
  always_comb begin
    end_sum = $signed({3'b000, in_range_first[FIELD_W-2:0]}) +
              $signed({2'b00, in_range_length});
    eff_sh  = in_range_shift[FIELD_W-1] ?
              $signed({2'b00, in_range_length}) + $signed({{2{in_range_shift[FIELD_W-1]}},
              in_range_shift}) : $signed({{2{in_range_shift[FIELD_W-1]}}, in_range_shift});
    c        = '0;
    c.act    = action_t'(in_action);
    c.idx    = in_entry_index;
    c.idx_ok = 1'b1;
    c.color  = in_entry_color;
    c.clear  = in_range_first[FIELD_W-1];
    c.first  = in_range_first[IDX_W-1:0];
    c.len    = in_range_length;
    c.shift  = eff_sh[FIELD_W-1:0];
    c.add_ok = !in_range_first[FIELD_W-1] && (in_range_length >= FIELD_W'(2)) &&
               (end_sum <= $signed((FIELD_W+2)'(PAL_ENTRIES))) &&
               (eff_sh >= 0) && (eff_sh <= $signed({2'b00, in_range_length}));
  end

  assign in_stall = (cnt_r == ($clog2(QDEPTH)+1)'(QDEPTH));
  assign push     = in_valid && !in_stall;
  assign q_valid  = (cnt_r != '0);
  assign q_cmd    = mem_r[rp_r];

  always_comb begin
    cnt_nxt = cnt_r + ($clog2(QDEPTH)+1)'(push) - ($clog2(QDEPTH)+1)'(q_pop);
  end

  // Advance queue pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push)  wp_r <= ~wp_r;
      if (q_pop) rp_r <= ~rp_r;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= c;
  end

`ifndef ASSERT_OFF
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid) else $error("pop from empty queue");
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= ($clog2(QDEPTH)+1)'(QDEPTH)) else $error("queue count overflow");
  a_push_count: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !q_pop) |=> cnt_r == $past(cnt_r) + 1'b1) else $error("push lost");
`endif
endmodule

[design/pcc_back.sv]
// Back end: palette store, range table, tick sequencer and result register
module pcc_back (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_en,
  input  logic                           q_valid,
  input  pcc_pkg::cmd_t                  q_cmd,
  output logic                           q_pop,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [pcc_pkg::COLOR_W-1:0]    out_read_color,
  output logic [pcc_pkg::CNT_W-1:0]      out_ranges_in_use,
  output logic                           busy
);
  import pcc_pkg::*;

  logic [COLOR_W-1:0] work_mem [PAL_ENTRIES];
  logic [COLOR_W-1:0] snap_mem [PAL_ENTRIES];
  logic [PAL_ENTRIES-1:0] wvld_r;
  logic [IDX_W-1:0]   rs_r [MAX_RANGES];
  logic [FIELD_W-1:0] rl_r [MAX_RANGES];
  logic [FIELD_W-1:0] rh_r [MAX_RANGES];
  logic [CNT_W-1:0]   rcnt_r;

  bstate_t st_r, st_nxt;
  logic [IDX_W:0]     k_r;        // sweep index
  logic [RNG_W-1:0]   r_r;        // current range
  logic [FIELD_W-1:0] j_r;        // rotated offset
  logic               rdv_r;      // read data stage valid
  logic [IDX_W-1:0]   rd_dst_r;
  logic [COLOR_W-1:0] work_q, snap_q;
  logic [COLOR_W-1:0] oc_r;
  logic [CNT_W-1:0]   on_r;
  logic               ov_r;
  logic               is_rd_r;
  logic               w_we, s_we;
  logic [IDX_W-1:0]   w_wa, w_ra, s_ra, s_wa;
  logic [COLOR_W-1:0] w_wd;
  logic [FIELD_W:0]   j_inc;
  logic [FIELD_W-1:0] cur_len;

  assign out_valid         = ov_r;
  assign out_read_color    = oc_r;
  assign out_ranges_in_use = on_r;
  assign busy              = (st_r != ST_IDLE);
  assign cur_len           = rl_r[r_r];
  assign j_inc             = {1'b0, j_r} + 1'b1;

  // Next state and memory controls
  always_comb begin
    st_nxt = st_r;
    q_pop  = 1'b0;
    w_we   = 1'b0;
    w_wa   = q_cmd.idx;
    w_wd   = q_cmd.color;
    w_ra   = q_cmd.idx;
    s_we   = 1'b0;
    s_wa   = rd_dst_r;
    s_ra   = rs_r[r_r] + j_r[IDX_W-1:0];
    unique case (st_r)
      ST_IDLE: begin
        if (q_valid && !ov_r) begin
          q_pop = 1'b1;
          unique case (q_cmd.act)
            ACT_WRITE: begin
              w_we   = 1'b1;
              st_nxt = ST_OUT;
            end
            ACT_READ: st_nxt = ST_RD;
            ACT_ADD:  st_nxt = ST_OUT;
            ACT_TICK: st_nxt = cfg_en ? ST_SNAP : ST_OUT;
            default:  st_nxt = ST_OUT;
          endcase
        end
      end
      ST_SNAP: begin
        w_ra = k_r[IDX_W-1:0];
        s_we = rdv_r;
        if (!rdv_r && k_r == (IDX_W+1)'(PAL_ENTRIES))
          st_nxt = (rcnt_r == '0) ? ST_OUT : ST_RNG;
      end
      ST_RNG: begin
        w_we = rdv_r;
        w_wa = rd_dst_r;
        w_wd = snap_q;
        if (!rdv_r && k_r[FIELD_W-1:0] == cur_len && k_r != '0 &&
            r_r == RNG_W'(rcnt_r - 1'b1))
          st_nxt = ST_OUT;
      end
      // Hold the read address on the popped entry
      ST_RD: begin
        w_ra   = rd_dst_r;
        st_nxt = ST_OUT;
      end
      ST_OUT: st_nxt = ST_IDLE;
      default: st_nxt = ST_IDLE;
    endcase
  end

  // Memories: registered reads
  always_ff @(posedge clk) begin
    if (w_we) work_mem[w_wa] <= w_wd;
    work_q <= work_mem[w_ra];
    if (s_we) snap_mem[s_wa] <= wvld_r[rd_dst_r] ? work_q : '0;
    snap_q <= snap_mem[s_ra];
  end

  // Sequencer and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= ST_IDLE;
      ov_r   <= 1'b0;
      rcnt_r <= '0;
      wvld_r <= '0;
      k_r    <= '0;
      r_r    <= '0;
      j_r    <= '0;
      rdv_r  <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (ov_r && !out_stall) ov_r <= 1'b0;
      if (w_we) wvld_r[w_wa] <= 1'b1;
      rdv_r <= 1'b0;
      unique case (st_r)
        ST_IDLE: begin
          k_r <= '0;
          r_r <= '0;
          j_r <= '0;
          if (q_valid && !ov_r) begin
            is_rd_r <= (q_cmd.act == ACT_READ);
            rd_dst_r <= q_cmd.idx;
            oc_r <= '0;
            on_r <= '0;
            if (q_cmd.act == ACT_ADD) begin
              if (q_cmd.clear) rcnt_r <= '0;
              else if (cfg_en && q_cmd.add_ok && rcnt_r < CNT_W'(MAX_RANGES)) begin
                rs_r[RNG_W'(rcnt_r)] <= q_cmd.first;
                rl_r[RNG_W'(rcnt_r)] <= q_cmd.len;
                rh_r[RNG_W'(rcnt_r)] <= q_cmd.shift;
                rcnt_r <= rcnt_r + 1'b1;
                on_r   <= rcnt_r + 1'b1;
              end
            end
          end
        end
        ST_SNAP: begin
          if (k_r != (IDX_W+1)'(PAL_ENTRIES)) begin
            rd_dst_r <= k_r[IDX_W-1:0];
            rdv_r    <= 1'b1;
            k_r      <= k_r + 1'b1;
          end else if (!rdv_r) begin
            k_r <= '0;
            r_r <= '0;
            j_r <= (rh_r[0] == rl_r[0]) ? '0 : rh_r[0];
          end
        end
        ST_RNG: begin
          if (k_r[FIELD_W-1:0] != cur_len) begin
            rd_dst_r <= rs_r[r_r] + k_r[IDX_W-1:0];
            rdv_r    <= 1'b1;
            k_r      <= k_r + 1'b1;
            j_r      <= (j_inc >= {1'b0, cur_len}) ? j_inc[FIELD_W-1:0] - cur_len
                                                   : j_inc[FIELD_W-1:0];
          end else if (!rdv_r) begin
            k_r <= '0;
            r_r <= r_r + 1'b1;
            j_r <= (rh_r[r_r + 1'b1] == rl_r[r_r + 1'b1]) ? '0 : rh_r[r_r + 1'b1];
          end
        end
        ST_RD: ;
        ST_OUT: begin
          ov_r <= 1'b1;
          if (is_rd_r) oc_r <= wvld_r[rd_dst_r] ? work_q : '0;
          is_rd_r <= 1'b0;
        end
        default: ;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_cnt_max: assert property (@(posedge clk) disable iff (!rst_n)
    rcnt_r <= CNT_W'(MAX_RANGES)) else $error("range count overflow");
  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> (st_r == ST_IDLE && !ov_r)) else $error("pop while busy");
  a_out_after: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(ov_r) |-> $past(st_r) == ST_OUT) else $error("result without command");
`endif
endmodule

[design/palette_color_cycler.sv]
// Top level of the palette color cycler
//  channel | direction | handshake      | payload
//  in_     | input     | valid / stall  | action, index, color, range fields
//  out_    | output    | valid / stall  | read_color, ranges_in_use
//  cfg_    | input     | valid / ready  | cycling_enable
// Write, read and add each give one result; an enabled tick sweeps the
// palette into the snapshot memory and then writes each rotated range back
// from it, one entry at a time. Synchronous active-low reset; the palette
// reads zero until written. A two-entry queue lets the front accept while
// the back works; a stalled result holds the back end.
module palette_color_cycler (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic [1:0]                             in_action,
  input  logic [7:0]                             in_entry_index,
  input  logic [17:0]                            in_entry_color,
  input  logic signed [8:0]                      in_range_first,
  input  logic [8:0]                             in_range_length,
  input  logic signed [8:0]                      in_range_shift,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic [17:0]                            out_read_color,
  output logic [3:0]                             out_ranges_in_use,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic                                   cfg_cycling_enable
);
  import pcc_pkg::*;

  logic  q_valid, q_pop, busy;
  cmd_t  q_cmd;
  logic  en_r;

  assign cfg_ready = 1'b1;

  // Hold the enable register
  always_ff @(posedge clk) begin
    if (!rst_n) en_r <= 1'b0;
    else if (cfg_valid) en_r <= cfg_cycling_enable;
  end

  pcc_front u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_action, .in_entry_index,
    .in_entry_color, .in_range_first, .in_range_length, .in_range_shift,
    .q_valid, .q_cmd, .q_pop
  );

  pcc_back u_back (
    .clk, .rst_n, .cfg_en(en_r), .q_valid, .q_cmd, .q_pop,
    .out_valid, .out_stall, .out_read_color, .out_ranges_in_use, .busy
  );

`ifndef ASSERT_OFF
  a_busy_noout: assert property (@(posedge clk) disable iff (!rst_n)
    (busy && !q_valid) |-> !q_pop) else $error("pop with empty queue");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> out_valid) else $error("result dropped");
  a_cfg: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid |=> en_r == $past(cfg_cycling_enable)) else $error("enable lost");
`endif
endmodule
